### rtl/core/pidt_pkg.sv
// shared types and constants for the timestamped pid controller
`default_nettype none

package pidt_pkg;

  // field and datapath widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MCAND_W  = 49;
  localparam int unsigned PROD_W   = MCAND_W + WORD_W;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned FACTOR_W = 51;
  localparam int unsigned IDX_W    = 3;

  // constants of the control law
  localparam logic [WORD_W-1:0]   MS_PER_SEC = 32'd1000;
  localparam logic [FACTOR_W-1:0] Q_ONE      = 51'd65536;
  localparam logic [WORD_W-1:0]   S32_MAX    = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0]   S32_MIN    = 32'h8000_0000;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_TARGET     = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
  localparam logic [IDX_W-1:0] REG_INTEG_MAX  = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEG_MIN  = 3'd5;
  localparam logic [IDX_W-1:0] REG_START_TIME = 3'd6;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_INC,
    ST_DIV_INC,
    ST_INTEG,
    ST_DIV_DER,
    ST_DER_SAT,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_I,
    ST_ACC_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_MUL_T,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### rtl/core/pid_controller_timestamped.sv
// top level: sequencer and datapath of the timestamped pid controller
//
// Each item runs through these steps in turn. Five passes of the shared
// bit-serial multiplier, each made of launch, 32 shift steps and handoff,
// serve the increment, the three gains and the final scale. Two passes of the
// shared bit-serial divider serve the integral increment by 1000 and the
// derivative by the interval. Eight further steps make up the rest, counting
// the idle step that accepts the item. On a zero interval the derivative
// division and its saturation step are skipped. One item is worked at a time.
// A new item is taken once the previous one has left the sequencer, even while
// its result still waits in the output register. A result that is still held
// when the next one is ready stalls the sequencer in its finishing step. The
// result holds drive in tdata and the saturated flag in tuser.
`default_nettype none

module pid_controller_timestamped
  import pidt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  // input items
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [63:0]       s_tdata,   // [31:0] measured, [63:32] time_ms
  // result items
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [WORD_W-1:0]      m_tdata,   // [31:0] drive
  output logic                   m_tuser    // [0] saturated
);

  state_t state, state_next;

  // configuration registers
  logic [WORD_W-1:0] target, kp, ki, kd, imax, imin;

  // controller state
  logic [WORD_W-1:0] last_error, integral, last_time;

  // item datapath
  logic [WORD_W-1:0]   meas, now_ms, err, dt, deriv;
  logic [FACTOR_W-1:0] factor;
  logic [42:0]         dmag1000;
  logic [PROD_W-1:0]   res;
  logic                neg;
  logic                launched;

  // unit interface
  unit_stat_t        mul_st, div_st;
  logic [PROD_W-1:0] mul_p;
  logic [DVD_W-1:0]  div_q;
  logic              start, mul_start, div_start, mul_state, div_state, sign_sel;
  logic [MCAND_W-1:0] mcand;
  logic [WORD_W-1:0]  mplier;
  logic [DVD_W-1:0]   dividend;
  logic [WORD_W-1:0]  divisor;
  logic               out_free;

  // combinational datapath terms
  logic [32:0]         ediff;
  logic [WORD_W-1:0]   err_sat;
  logic [55:0]         incr, cand;
  logic                cand_ok;
  logic [32:0]         ddiff, dmag;
  logic [42:0]         dq;
  logic [WORD_W-1:0]   der_sat;
  logic [63:0]         gprod;
  logic [FACTOR_W-1:0] gterm;
  logic [FACTOR_W-1:0] fmag;
  logic [81:0]         tprod;
  logic [65:0]         tshift;
  logic [WORD_W-1:0]   drive_val;
  logic                drive_clip;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_ERR;
      ST_ERR:     state_next = ST_MUL_INC;
      ST_MUL_INC: if (mul_st.done) state_next = ST_DIV_INC;
      ST_DIV_INC: if (div_st.done) state_next = ST_INTEG;
      ST_INTEG:   state_next = (dt == '0) ? ST_MUL_P : ST_DIV_DER;
      ST_DIV_DER: if (div_st.done) state_next = ST_DER_SAT;
      ST_DER_SAT: state_next = ST_MUL_P;
      ST_MUL_P:   if (mul_st.done) state_next = ST_ACC_P;
      ST_ACC_P:   state_next = ST_MUL_I;
      ST_MUL_I:   if (mul_st.done) state_next = ST_ACC_I;
      ST_ACC_I:   state_next = ST_MUL_D;
      ST_MUL_D:   if (mul_st.done) state_next = ST_ACC_D;
      ST_ACC_D:   state_next = ST_MUL_T;
      ST_MUL_T:   if (mul_st.done) state_next = ST_FINISH;
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // unit launch and operand selection
  always_comb begin
    mul_state = 1'b0;
    div_state = 1'b0;
    mcand     = '0;
    mplier    = '0;
    sign_sel  = 1'b0;
    dividend  = res[DVD_W-1:0];
    divisor   = MS_PER_SEC;
    fmag      = factor[FACTOR_W-1] ? -factor : factor;
    unique case (state)
      ST_MUL_INC: begin
        mul_state = 1'b1;
        mcand     = {17'd0, err[31] ? -err : err};
        mplier    = dt;
        sign_sel  = err[31];
      end
      ST_DIV_INC: begin
        div_state = 1'b1;
        dividend  = res[63:0];
        divisor   = MS_PER_SEC;
      end
      ST_DIV_DER: begin
        div_state = 1'b1;
        dividend  = {21'd0, dmag1000};
        divisor   = dt;
      end
      ST_MUL_P: begin
        mul_state = 1'b1;
        mcand     = {17'd0, kp[31] ? -kp : kp};
        mplier    = err[31] ? -err : err;
        sign_sel  = kp[31] ^ err[31];
      end
      ST_MUL_I: begin
        mul_state = 1'b1;
        mcand     = {17'd0, ki[31] ? -ki : ki};
        mplier    = integral[31] ? -integral : integral;
        sign_sel  = ki[31] ^ integral[31];
      end
      ST_MUL_D: begin
        mul_state = 1'b1;
        mcand     = {17'd0, kd[31] ? -kd : kd};
        mplier    = deriv[31] ? -deriv : deriv;
        sign_sel  = kd[31] ^ deriv[31];
      end
      ST_MUL_T: begin
        mul_state = 1'b1;
        mcand     = fmag[MCAND_W-1:0];
        mplier    = target[31] ? -target : target;
        sign_sel  = target[31] ^ factor[FACTOR_W-1];
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    start     = (mul_state || div_state) && !launched;
    mul_start = start && mul_state;
    div_start = start && div_state;
  end

  // datapath arithmetic
  always_comb begin
    ediff   = {target[31], target} - {meas[31], meas};
    err_sat = (ediff[32] != ediff[31]) ? (ediff[32] ? S32_MIN : S32_MAX) : ediff[31:0];
    incr    = neg ? -{2'b00, res[53:0]} : {2'b00, res[53:0]};
    cand    = {{24{integral[31]}}, integral} + incr;
    cand_ok = ($signed(cand) <= $signed({{24{imax[31]}}, imax}))
           && ($signed(cand) >= $signed({{24{imin[31]}}, imin}));
    ddiff   = {err[31], err} - {last_error[31], last_error};
    dmag    = ddiff[32] ? -ddiff : ddiff;
    dq      = res[42:0];
    if (!neg) begin
      der_sat = (dq > {11'd0, S32_MAX}) ? S32_MAX : dq[31:0];
    end else begin
      der_sat = (dq > {11'd0, S32_MIN}) ? S32_MIN : -dq[31:0];
    end
    gprod   = neg ? -res[63:0] : res[63:0];
    gterm   = {{3{gprod[63]}}, gprod[63:16]};
    tprod   = neg ? -{1'b0, res} : {1'b0, res};
    tshift  = tprod[81:16];
    drive_clip = (tshift[65:31] != '0) && (tshift[65:31] != '1);
    drive_val  = drive_clip ? (tshift[65] ? S32_MIN : S32_MAX) : tshift[31:0];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launched   <= 1'b0;
      m_tvalid   <= 1'b0;
      target     <= '0;
      kp         <= '0;
      ki         <= '0;
      kd         <= '0;
      imax       <= S32_MAX;
      imin       <= S32_MIN;
      last_error <= '0;
      integral   <= '0;
      last_time  <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        launched <= 1'b1;
      end else if (mul_st.done || div_st.done) begin
        launched <= 1'b0;
      end
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET:     target    <= cfg_data;
          REG_GAIN_PROP:  kp        <= cfg_data;
          REG_GAIN_INTEG: ki        <= cfg_data;
          REG_GAIN_DERIV: kd        <= cfg_data;
          REG_INTEG_MAX:  imax      <= cfg_data;
          REG_INTEG_MIN:  imin      <= cfg_data;
          REG_START_TIME: last_time <= cfg_data;
          default:        ;
        endcase
      end
      // integral update, taken only when the candidate lies inside the bounds
      if (state == ST_INTEG && cand_ok) begin
        integral <= cand[31:0];
      end
      // result handoff
      if (state == ST_FINISH && out_free) begin
        m_tvalid   <= 1'b1;
        last_error <= err;
        last_time  <= now_ms;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      meas   <= s_tdata[31:0];
      now_ms <= s_tdata[63:32];
      factor <= Q_ONE;
    end
    if (mul_start) begin
      neg <= sign_sel;
    end
    if (mul_st.done) begin
      res <= mul_p;
    end
    if (div_st.done) begin
      res <= {17'd0, div_q};
    end
    unique case (state)
      ST_ERR: begin
        err <= err_sat;
        dt  <= now_ms - last_time;
      end
      ST_INTEG: begin
        neg      <= ddiff[32];
        dmag1000 <= ({10'd0, dmag} << 10) - ({10'd0, dmag} << 4) - ({10'd0, dmag} << 3);
        deriv    <= '0;
      end
      ST_DER_SAT: deriv <= der_sat;
      ST_ACC_P, ST_ACC_I, ST_ACC_D: factor <= factor + gterm;
      ST_FINISH: begin
        if (out_free) begin
          m_tdata <= drive_val;
          m_tuser <= drive_clip;
        end
      end
      default: ;
    endcase
  end

  pidt_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .stat   (mul_st),
    .prod   (mul_p)
  );

  pidt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_st),
    .quot     (div_q)
  );

  // the two serial units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_st.busy && div_st.busy))
    else $error("multiplier and divider busy together");

  // derivative division only runs on a nonzero interval
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (div_start && state == ST_DIV_DER) |-> (dt != '0))
    else $error("derivative division launched on zero interval");

  // an integral change always lands inside the bounds
  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INTEG && !cfg_we) |=> (integral == $past(integral)
      || ($signed(integral) <= $signed(imax) && $signed(integral) >= $signed(imin))))
    else $error("integral left its bounds");

  // a new result only comes from the finishing step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finishing step");

endmodule

`default_nettype wire

### rtl/core/pidt_mul.sv
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module pidt_mul
  import pidt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MCAND_W-1:0] mcand,
  input  wire logic [WORD_W-1:0]  mplier,
  output unit_stat_t              stat,
  output logic [PROD_W-1:0]       prod
);

  logic [4:0]       count;
  logic [MCAND_W:0] sum;
  logic             busy;
  logic             done;
  logic [MCAND_W-1:0] mcand_r;

  // add multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, prod[PROD_W-1:WORD_W]} + (prod[0] ? {1'b0, mcand_r} : '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      prod    <= {{MCAND_W{1'b0}}, mplier};
    end else if (busy) begin
      prod <= {sum, prod[WORD_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### rtl/core/pidt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module pidt_div
  import pidt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output unit_stat_t             stat,
  output logic [DVD_W-1:0]       quot
);

  logic [5:0]        count;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W:0]   trial;
  logic              busy;
  logic              done;

  // trial subtraction of the divisor from the shifted remainder
  assign trial = {rem, quot[DVD_W-1]} - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      if (!trial[WORD_W]) begin
        rem  <= trial[WORD_W-1:0];
        quot <= {quot[DVD_W-2:0], 1'b1};
      end else begin
        rem  <= {rem[WORD_W-2:0], quot[DVD_W-1]};
        quot <= {quot[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire
